[sv/rbs_pkg.sv]
// shared constants, codes and types of the restart backoff supervisor
package rbs_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int TIME_W     = 48;
	localparam int DELAY_W    = 24;
	localparam int BO_W       = DELAY_W + 1;
	localparam int FAIL_W     = 6;
	localparam int WIN_W      = 32;
	localparam int USE_W      = 5;
	localparam int ACT_W      = 3;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [ACT_W-1:0] ACT_FAILURE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_EXIT     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SPAWN    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TICK     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DISPATCH = 3'd4;

	localparam logic [KIND_W-1:0] KIND_ACK         = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RESPAWN     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GRANT       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NONE        = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOTHING_DUE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_INITIAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_BUDGET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE    = 3'd4;

	localparam logic [DELAY_W-1:0] BACKOFF_INITIAL_RST = 24'd100;
	localparam logic [DELAY_W-1:0] BACKOFF_MAX_RST     = 24'd30000;
	localparam logic [FAIL_W-1:0]  FAILURE_BUDGET_RST  = 6'd5;
	localparam logic [WIN_W-1:0]   WINDOW_RST          = 32'd60000;
	localparam logic [USE_W-1:0]   SLOTS_IN_USE_RST    = 5'd16;

	localparam logic [FAIL_W-1:0] FAIL_SAT = 6'd63;

	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic [DELAY_W-1:0] backoff_initial_ms;
		logic [DELAY_W-1:0] backoff_max_ms;
		logic [FAIL_W-1:0]  failure_budget;
		logic [WIN_W-1:0]   window_ms;
		logic [CNT_W-1:0]   n_slots;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] due_ms;
		logic [TIME_W-1:0] opened_ms;
		logic [FAIL_W-1:0] failures;
	} slot_entry_t;

endpackage

[sv/rbs_req_if.sv]
// event channel into the supervisor
interface rbs_req_if;
	logic                         valid;
	logic                         ready;
	logic [rbs_pkg::ACT_W-1:0]    action;
	logic [rbs_pkg::SLOT_W-1:0]   slot;
	logic [rbs_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, output action, output slot, output now_ms, input ready);
	modport sink   (input valid, input action, input slot, input now_ms, output ready);
endinterface

[sv/rbs_rsp_if.sv]
// result channel out of the supervisor
interface rbs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rbs_pkg::KIND_W-1:0]    kind;
	logic [rbs_pkg::SLOT_W-1:0]    target_slot;
	logic                          fatal;
	logic [rbs_pkg::DELAY_W-1:0]   scheduled_delay_ms;
	logic                          last;

	modport source (output valid, output kind, output target_slot, output fatal,
		output scheduled_delay_ms, output last, input ready);
	modport sink   (input valid, input kind, input target_slot, input fatal,
		input scheduled_delay_ms, input last, output ready);
endinterface

[sv/rbs_cfg_if.sv]
// register write channel of the supervisor
interface rbs_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rbs_pkg::CFG_IDX_W-1:0]    index;
	logic [rbs_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/restart_backoff_supervisor.sv]
// restart backoff supervisor top level with its sequencer
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------------------------
//  req     | in  | action, slot, now_ms
//  rsp     | out | kind, target_slot, fatal, scheduled_delay_ms, last
//  cfg     | in  | index, data (register write, always ready)
//
// one event at a time; req.ready is high only while the sequencer is idle
// failure: read, age, window, up to failures - 1 backoff doublings, cap, due, emit;
// fatal ones emit after window; tick: read and compare per slot, end; dispatch: wrap
// cursor, scan slots; failure and tick steps share one 48-bit add/compare unit
// a result waits in the output register; a stalled rsp holds the sequencer
// arst_n clears all slot state, the cursor and the fatal flag at once
module restart_backoff_supervisor (
	input  logic      clk,
	input  logic      arst_n,
	rbs_req_if.sink   req,
	rbs_rsp_if.source rsp,
	rbs_cfg_if.sink   cfg
);
	import rbs_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EMIT   = 4'd1;
	localparam logic [3:0] S_F_RD   = 4'd2;
	localparam logic [3:0] S_F_AGE  = 4'd3;
	localparam logic [3:0] S_F_WIN  = 4'd4;
	localparam logic [3:0] S_F_BO   = 4'd5;
	localparam logic [3:0] S_F_CAP  = 4'd6;
	localparam logic [3:0] S_F_DUE  = 4'd7;
	localparam logic [3:0] S_T_RD   = 4'd8;
	localparam logic [3:0] S_T_CMP  = 4'd9;
	localparam logic [3:0] S_T_END  = 4'd10;
	localparam logic [3:0] S_D_MOD  = 4'd11;
	localparam logic [3:0] S_D_SCAN = 4'd12;

	cfg_t cfg_w;

	logic [3:0]         state_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TIME_W-1:0]  now_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FAIL_W-1:0]  bo_cnt_q;
	logic [TIME_W-1:0]  age_q;
	logic [FAIL_W-1:0]  fails_q;
	logic [TIME_W-1:0]  opened_q;
	logic [BO_W-1:0]    b_q;
	logic [SLOTS-1:0]   active_q;
	logic [SLOTS-1:0]   pending_q;
	logic               fatal_q;
	logic [SLOT_W-1:0]  cursor_q;
	logic               hold_vld_q;
	logic [SLOT_W-1:0]  hold_slot_q;
	logic [KIND_W-1:0]  res_kind_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic [DELAY_W-1:0] res_delay_q;

	logic               rsp_vld_q;
	logic [KIND_W-1:0]  rsp_kind_q;
	logic [SLOT_W-1:0]  rsp_slot_q;
	logic               rsp_fatal_q;
	logic [DELAY_W-1:0] rsp_delay_q;
	logic               rsp_last_q;

	logic               out_free;
	logic               req_xfer;
	logic               slot_ok;

	logic [SLOT_W-1:0]  tbl_addr;
	slot_entry_t        tbl_rd;
	logic               tbl_we;
	slot_entry_t        tbl_wd;

	logic               alu_op;
	logic [TIME_W-1:0]  alu_a;
	logic [TIME_W-1:0]  alu_b;
	logic [TIME_W-1:0]  alu_res;
	logic               alu_carry;

	logic               new_win;
	logic [FAIL_W-1:0]  fails_new;
	logic [TIME_W-1:0]  opened_new;
	logic               fatal_now;
	logic               t_hit;
	logic               t_last;
	logic               d_wrap;

	logic               emit_go;
	logic [KIND_W-1:0]  emit_kind;
	logic [SLOT_W-1:0]  emit_slot;
	logic [DELAY_W-1:0] emit_delay;
	logic               emit_last;

	rbs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_w)
	);

	rbs_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (tbl_addr),
		.rd_data (tbl_rd),
		.wr_en   (tbl_we),
		.wr_addr (slot_q),
		.wr_data (tbl_wd)
	);

	rbs_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.carry (alu_carry)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign slot_ok   = ({1'b0, req.slot} < cfg_w.n_slots);
	assign tbl_addr  = (state_q == S_T_RD || state_q == S_T_CMP) ? idx_q : slot_q;

	assign rsp.valid              = rsp_vld_q;
	assign rsp.kind               = rsp_kind_q;
	assign rsp.target_slot        = rsp_slot_q;
	assign rsp.fatal              = rsp_fatal_q;
	assign rsp.scheduled_delay_ms = rsp_delay_q;
	assign rsp.last               = rsp_last_q;

	// operand selection for the shared unit
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_F_AGE: begin
				alu_op = ALU_SUB;
				alu_a  = now_q;
				alu_b  = tbl_rd.opened_ms;
			end
			S_F_WIN: begin
				alu_op = ALU_SUB;
				alu_a  = TIME_W'(cfg_w.window_ms);
				alu_b  = age_q;
			end
			S_F_BO: begin
				alu_op = ALU_SUB;
				alu_a  = TIME_W'(b_q);
				alu_b  = TIME_W'(cfg_w.backoff_max_ms);
			end
			S_F_CAP: begin
				alu_op = ALU_SUB;
				alu_a  = TIME_W'(cfg_w.backoff_max_ms);
				alu_b  = TIME_W'(b_q);
			end
			S_F_DUE: begin
				alu_op = ALU_ADD;
				alu_a  = now_q;
				alu_b  = TIME_W'(b_q);
			end
			S_T_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = now_q;
				alu_b  = tbl_rd.due_ms;
			end
			default: begin
			end
		endcase
	end

	// window update of a failure
	always_comb begin
		new_win = (tbl_rd.opened_ms == '0) || !alu_carry;
		if (new_win) begin
			fails_new  = FAIL_W'(1);
			opened_new = now_q;
		end else begin
			fails_new  = (tbl_rd.failures < FAIL_SAT) ? tbl_rd.failures + FAIL_W'(1)
				: tbl_rd.failures;
			opened_new = tbl_rd.opened_ms;
		end
		fatal_now = (fails_new > cfg_w.failure_budget);
	end

	assign t_hit  = pending_q[idx_q] && alu_carry;
	assign t_last = (CNT_W'(idx_q) + CNT_W'(1)) == cfg_w.n_slots;
	assign d_wrap = (CNT_W'(idx_q) + CNT_W'(1)) == cfg_w.n_slots;

	always_comb begin
		tbl_we = 1'b0;
		tbl_wd = tbl_rd;
		if (state_q == S_F_WIN && fatal_now) begin
			tbl_we           = 1'b1;
			tbl_wd.opened_ms = opened_new;
			tbl_wd.failures  = fails_new;
		end else if (state_q == S_F_DUE) begin
			tbl_we           = 1'b1;
			tbl_wd.due_ms    = alu_res;
			tbl_wd.opened_ms = opened_q;
			tbl_wd.failures  = fails_q;
		end
	end

	// result into the output register
	always_comb begin
		emit_go    = 1'b0;
		emit_kind  = res_kind_q;
		emit_slot  = res_slot_q;
		emit_delay = res_delay_q;
		emit_last  = 1'b1;
		if (state_q == S_EMIT) begin
			emit_go = out_free;
		end else if (state_q == S_T_CMP && t_hit && hold_vld_q) begin
			emit_go    = out_free;
			emit_kind  = KIND_RESPAWN;
			emit_slot  = hold_slot_q;
			emit_delay = '0;
			emit_last  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (emit_go) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp_kind_q  <= emit_kind;
			rsp_slot_q  <= emit_slot;
			rsp_fatal_q <= fatal_q;
			rsp_delay_q <= emit_delay;
			rsp_last_q  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			pending_q   <= '0;
			fatal_q     <= 1'b0;
			cursor_q    <= '0;
			hold_vld_q  <= 1'b0;
			hold_slot_q <= '0;
			slot_q      <= '0;
			now_q       <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			bo_cnt_q    <= '0;
			age_q       <= '0;
			fails_q     <= '0;
			opened_q    <= '0;
			b_q         <= '0;
			res_kind_q  <= KIND_ACK;
			res_slot_q  <= '0;
			res_delay_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						slot_q      <= req.slot;
						now_q       <= req.now_ms;
						res_kind_q  <= KIND_ACK;
						res_slot_q  <= '0;
						res_delay_q <= '0;
						unique case (req.action)
							ACT_FAILURE: begin
								state_q <= slot_ok ? S_F_RD : S_EMIT;
							end
							ACT_EXIT: begin
								if (slot_ok) begin
									active_q[req.slot] <= 1'b0;
								end
								state_q <= S_EMIT;
							end
							ACT_SPAWN: begin
								if (slot_ok) begin
									active_q[req.slot] <= 1'b1;
								end
								state_q <= S_EMIT;
							end
							ACT_TICK: begin
								idx_q      <= '0;
								hold_vld_q <= 1'b0;
								state_q    <= S_T_RD;
							end
							ACT_DISPATCH: begin
								idx_q   <= cursor_q;
								state_q <= S_D_MOD;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_F_RD: begin
					state_q <= S_F_AGE;
				end
				S_F_AGE: begin
					age_q   <= alu_res;
					state_q <= S_F_WIN;
				end
				S_F_WIN: begin
					active_q[slot_q] <= 1'b0;
					if (fatal_now) begin
						fatal_q           <= 1'b1;
						pending_q[slot_q] <= 1'b0;
						state_q           <= S_EMIT;
					end else begin
						fails_q  <= fails_new;
						opened_q <= opened_new;
						b_q      <= BO_W'(cfg_w.backoff_initial_ms);
						bo_cnt_q <= FAIL_W'(1);
						state_q  <= S_F_BO;
					end
				end
				S_F_BO: begin
					if (bo_cnt_q >= fails_q || alu_carry) begin
						state_q <= S_F_CAP;
					end else begin
						b_q      <= {b_q[BO_W-2:0], 1'b0};
						bo_cnt_q <= bo_cnt_q + FAIL_W'(1);
					end
				end
				S_F_CAP: begin
					if (!alu_carry) begin
						b_q <= BO_W'(cfg_w.backoff_max_ms);
					end
					state_q <= S_F_DUE;
				end
				S_F_DUE: begin
					pending_q[slot_q] <= 1'b1;
					res_delay_q       <= b_q[DELAY_W-1:0];
					state_q           <= S_EMIT;
				end
				S_T_RD: begin
					state_q <= S_T_CMP;
				end
				S_T_CMP: begin
					if (!(t_hit && hold_vld_q && !out_free)) begin
						if (t_hit) begin
							pending_q[idx_q] <= 1'b0;
							hold_vld_q       <= 1'b1;
							hold_slot_q      <= idx_q;
						end
						if (t_last) begin
							state_q <= S_T_END;
						end else begin
							idx_q   <= idx_q + SLOT_W'(1);
							state_q <= S_T_RD;
						end
					end
				end
				S_T_END: begin
					res_kind_q <= hold_vld_q ? KIND_RESPAWN : KIND_NOTHING_DUE;
					res_slot_q <= hold_vld_q ? hold_slot_q : '0;
					hold_vld_q <= 1'b0;
					state_q    <= S_EMIT;
				end
				S_D_MOD: begin
					if (CNT_W'(idx_q) >= cfg_w.n_slots) begin
						idx_q <= idx_q - cfg_w.n_slots[SLOT_W-1:0];
					end else begin
						cnt_q   <= '0;
						state_q <= S_D_SCAN;
					end
				end
				S_D_SCAN: begin
					if (active_q[idx_q]) begin
						cursor_q   <= d_wrap ? '0 : idx_q + SLOT_W'(1);
						res_kind_q <= KIND_GRANT;
						res_slot_q <= idx_q;
						state_q    <= S_EMIT;
					end else if (cnt_q + CNT_W'(1) == cfg_w.n_slots) begin
						res_kind_q <= KIND_NONE;
						state_q    <= S_EMIT;
					end else begin
						idx_q <= d_wrap ? '0 : idx_q + SLOT_W'(1);
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[sv/rbs_cfg_regs.sv]
// configuration registers and effective slot count
module rbs_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	rbs_cfg_if.sink       cfg,
	output rbs_pkg::cfg_t cfg_o
);
	import rbs_pkg::*;

	logic [DELAY_W-1:0] initial_q;
	logic [DELAY_W-1:0] max_q;
	logic [FAIL_W-1:0]  budget_q;
	logic [WIN_W-1:0]   window_q;
	logic [USE_W-1:0]   slots_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= BACKOFF_INITIAL_RST;
			max_q     <= BACKOFF_MAX_RST;
			budget_q  <= FAILURE_BUDGET_RST;
			window_q  <= WINDOW_RST;
			slots_q   <= SLOTS_IN_USE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BACKOFF_INITIAL: initial_q <= cfg.data[DELAY_W-1:0];
				CFG_BACKOFF_MAX:     max_q     <= cfg.data[DELAY_W-1:0];
				CFG_FAILURE_BUDGET:  budget_q  <= cfg.data[FAIL_W-1:0];
				CFG_WINDOW:          window_q  <= cfg.data[WIN_W-1:0];
				CFG_SLOTS_IN_USE:    slots_q   <= cfg.data[USE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg_o.backoff_initial_ms = initial_q;
		cfg_o.backoff_max_ms     = max_q;
		cfg_o.failure_budget     = budget_q;
		cfg_o.window_ms          = window_q;
		priority if (slots_q == '0) begin
			cfg_o.n_slots = CNT_W'(1);
		end else if (CNT_W'(slots_q) > CNT_W'(SLOTS)) begin
			cfg_o.n_slots = CNT_W'(SLOTS);
		end else begin
			cfg_o.n_slots = CNT_W'(slots_q);
		end
	end
endmodule

[sv/rbs_slot_table.sv]
// per-slot window and due-time storage, one registered read and one write port
module rbs_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rbs_pkg::SLOT_W-1:0]  rd_addr,
	output rbs_pkg::slot_entry_t        rd_data,
	input  logic                        wr_en,
	input  logic [rbs_pkg::SLOT_W-1:0]  wr_addr,
	input  rbs_pkg::slot_entry_t        wr_data
);
	import rbs_pkg::*;

	slot_entry_t entry_q [SLOTS];
	slot_entry_t rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				entry_q[i] <= '0;
			end
			rd_q <= '0;
		end else begin
			if (wr_en) begin
				entry_q[wr_addr] <= wr_data;
			end
			rd_q <= entry_q[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

[sv/rbs_alu.sv]
// shared 48-bit add / subtract-compare unit
module rbs_alu (
	input  logic                        op,
	input  logic [rbs_pkg::TIME_W-1:0]  a,
	input  logic [rbs_pkg::TIME_W-1:0]  b,
	output logic [rbs_pkg::TIME_W-1:0]  res,
	output logic                        carry
);
	import rbs_pkg::*;

	logic [TIME_W-1:0] b_op;
	logic [TIME_W:0]   sum;

	// on subtract, carry high means a >= b
	assign b_op = (op == ALU_SUB) ? ~b : b;
	assign sum  = {1'b0, a} + {1'b0, b_op} + {{TIME_W{1'b0}}, op};
	assign res   = sum[TIME_W-1:0];
	assign carry = sum[TIME_W];
endmodule
